// ----- hw/rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared codes, field widths and the sequencer state type of the sorted
// table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int OP_W          = 1;
    localparam int ENTRY_INDEX_W = 10;
    localparam int FIELD_KEY_W   = 32;
    localparam int POSITION_W    = 11;
    localparam int COUNT_W       = 11;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 11;

    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIGNED  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

// ----- hw/rtl/stbs_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted table storage
// Single-port-write, single-port-read table memory with a registered read.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of keys and answers searches over its sorted prefix with a
// found flag and either the matching index or the insertion point.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  input     in         start, taken when !busy   op, entry_index, entry_value,
//                                                 search_key
//  result    out        done (one-cycle strobe)   found, position
//  config    in         cfg_wr_en                 cfg_index, cfg_data
//
// A write item gives no result.
// A search item over n entries makes up to floor(log2(n))+1 probes, one per
// cycle, each a table read and a key compare; done comes the cycle after the
// last probe.
// An empty table gives done in the cycle after start.
// busy is high during the probes; rst_n clears the sequencer, done and the
// config registers, not the table. The receiver cannot stall, so done is never held.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [stbs_pkg::OP_W-1:0]            op,
    input  logic [stbs_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  logic [stbs_pkg::FIELD_KEY_W-1:0]     entry_value,
    input  logic [stbs_pkg::FIELD_KEY_W-1:0]     search_key,
    output logic                                 done,
    output logic                                 found,
    output logic [stbs_pkg::POSITION_W-1:0]      position,
    input  logic                                 cfg_wr_en,
    input  logic [stbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [stbs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] KEY_ONE = KEY_WIDTH'(1);
    localparam logic [KEY_WIDTH-1:0] KEY_TOP = KEY_ONE << (KEY_WIDTH - 1);

    stbs_pkg::state_t state_reg;
    stbs_pkg::state_t state_next;

    logic [stbs_pkg::COUNT_W-1:0]    entry_count_reg;
    logic                            key_signed_reg;

    logic [KEY_WIDTH-1:0]            key_reg;
    logic [KEY_WIDTH-1:0]            key_next;
    logic [CNT_W-1:0]                left_reg;
    logic [CNT_W-1:0]                left_next;
    logic [CNT_W-1:0]                right_reg;
    logic [CNT_W-1:0]                right_next;
    logic [CNT_W-1:0]                probe_reg;
    logic [CNT_W-1:0]                probe_next;
    logic                            done_reg;
    logic                            done_next;
    logic                            found_reg;
    logic                            found_next;
    logic [stbs_pkg::POSITION_W-1:0] position_reg;
    logic [stbs_pkg::POSITION_W-1:0] position_next;

    logic                            accept;
    logic [KEY_WIDTH-1:0]            value_key;
    logic [KEY_WIDTH-1:0]            search_key_cut;
    logic [CNT_W-1:0]                count_sat;
    logic [CNT_W-1:0]                count_half;
    logic [16:0]                     index_wide;
    logic                            index_ok;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [KEY_WIDTH-1:0]            rd_data;

    logic [KEY_WIDTH-1:0]            flip;
    logic [KEY_WIDTH-1:0]            entry_x;
    logic [KEY_WIDTH-1:0]            key_x;
    logic                            entry_less;
    logic                            entry_greater;

    logic [CNT_W-1:0]                a_left;
    logic [CNT_W-1:0]                a_probe;
    logic                            a_more;
    logic [CNT_W-1:0]                b_probe;
    logic                            b_more;

    generate
        if (KEY_WIDTH <= stbs_pkg::FIELD_KEY_W)
        begin : g_key_cut
            assign value_key      = entry_value[KEY_WIDTH-1:0];
            assign search_key_cut = search_key[KEY_WIDTH-1:0];
        end
        else
        begin : g_key_ext
            assign value_key      = {{(KEY_WIDTH - stbs_pkg::FIELD_KEY_W){1'b0}}, entry_value};
            assign search_key_cut = {{(KEY_WIDTH - stbs_pkg::FIELD_KEY_W){1'b0}}, search_key};
        end
    endgenerate

    assign accept = start && !busy;
    assign busy   = (state_reg == stbs_pkg::ST_SEARCH);

    assign count_sat  = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ?
                        CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_reg);
    assign count_half = count_sat >> 1;

    assign index_wide = 17'(entry_index);
    assign index_ok   = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign wr_en      = accept && (op == stbs_pkg::OP_WRITE) && index_ok;
    assign wr_addr    = index_wide[IDX_W-1:0];

    assign flip          = key_signed_reg ? KEY_TOP : '0;
    assign entry_x       = rd_data ^ flip;
    assign key_x         = key_reg ^ flip;
    assign entry_less    = (entry_x < key_x);
    assign entry_greater = (entry_x > key_x);

    // Both possible next windows are prepared in parallel with the key compare.
    assign a_left  = probe_reg + CNT_W'(1);
    assign a_probe = a_left + ((right_reg - a_left) >> 1);
    assign a_more  = (a_left < right_reg);
    assign b_probe = left_reg + ((probe_reg - left_reg) >> 1);
    assign b_more  = (left_reg < probe_reg);

    stbs_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            key_signed_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                stbs_pkg::REG_ENTRY_COUNT:
                begin
                    entry_count_reg <= cfg_data;
                end
                stbs_pkg::REG_KEY_SIGNED:
                begin
                    key_signed_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (accept && (op == stbs_pkg::OP_SEARCH) && (count_sat != '0))
                begin
                    state_next = stbs_pkg::ST_SEARCH;
                end
            end
            stbs_pkg::ST_SEARCH:
            begin
                if ((!entry_less && !entry_greater) ||
                    (entry_less && !a_more) ||
                    (entry_greater && !b_more))
                begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next      = key_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        probe_next    = probe_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        rd_en         = 1'b0;
        rd_addr       = probe_reg[IDX_W-1:0];
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (accept && (op == stbs_pkg::OP_SEARCH))
                begin
                    key_next   = search_key_cut;
                    left_next  = '0;
                    right_next = count_sat;
                    probe_next = count_half;
                    rd_addr    = count_half[IDX_W-1:0];
                    if (count_sat != '0)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        found_next    = 1'b0;
                        position_next = '0;
                    end
                end
            end
            stbs_pkg::ST_SEARCH:
            begin
                if (entry_less)
                begin
                    left_next  = a_left;
                    probe_next = a_probe;
                    rd_addr    = a_probe[IDX_W-1:0];
                    if (a_more)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        found_next    = 1'b0;
                        position_next = stbs_pkg::POSITION_W'(right_reg);
                    end
                end
                else if (entry_greater)
                begin
                    right_next = probe_reg;
                    probe_next = b_probe;
                    rd_addr    = b_probe[IDX_W-1:0];
                    if (b_more)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        found_next    = 1'b0;
                        position_next = stbs_pkg::POSITION_W'(probe_reg);
                    end
                end
                else
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = stbs_pkg::POSITION_W'(probe_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stbs_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        probe_reg    <= probe_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

`ifndef SYNTHESIS
    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stbs_pkg::ST_SEARCH) |->
            (left_reg <= probe_reg) && (probe_reg < right_reg))
        else $error("probe index outside the search window");

    a_window_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stbs_pkg::ST_SEARCH) && $past(state_reg == stbs_pkg::ST_SEARCH) |->
            ((right_reg - left_reg) < $past(right_reg - left_reg)))
        else $error("search window did not shrink between probes");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == stbs_pkg::OP_SEARCH) && (count_sat != '0) |=> busy)
        else $error("search item on a nonempty table did not start probing");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == stbs_pkg::OP_WRITE) |=> !done_reg && !busy)
        else $error("write item produced a result or started a search");

    a_done_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !$past(accept) |-> $past(state_reg == stbs_pkg::ST_SEARCH))
        else $error("result strobe without a search in progress");
`endif

endmodule

// ----- dv/stbs_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted table search checker
// Watches the item, result and register ports of the sorted table binary
// search block, keeps its own copy of the table and registers, predicts the
// outcome of every accepted search and compares each result as it appears.
// ----------------------------------------------------------------------------
module stbs_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [stbs_pkg::OP_W-1:0]            op,
    input  logic [stbs_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  logic [stbs_pkg::FIELD_KEY_W-1:0]     entry_value,
    input  logic [stbs_pkg::FIELD_KEY_W-1:0]     search_key,
    input  logic                                 done,
    input  logic                                 found,
    input  logic [stbs_pkg::POSITION_W-1:0]      position,
    input  logic                                 cfg_wr_en,
    input  logic [stbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [stbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending
);

    typedef struct packed {
        logic                            found;
        logic [stbs_pkg::POSITION_W-1:0] position;
    } search_result_t;

    logic [stbs_pkg::FIELD_KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [stbs_pkg::COUNT_W-1:0]     entry_count_q;
    logic                             signed_keys_q;
    search_result_t                   awaited_results [$];

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    function automatic search_result_t predict_search(
        input logic [stbs_pkg::FIELD_KEY_W-1:0] key);
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        logic           below;
        logic           above;
        search_result_t res;
        lo  = 0;
        hi  = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_q;
        res = '0;
        while (lo < hi && !res.found)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (signed_keys_q)
            begin
                below = $signed(key_store[mid]) < $signed(key);
                above = $signed(key_store[mid]) > $signed(key);
            end
            else
            begin
                below = key_store[mid] < key;
                above = key_store[mid] > key;
            end
            if (below)
                lo = mid + 1;
            else if (above)
                hi = mid;
            else
            begin
                res.found    = 1'b1;
                res.position = mid[stbs_pkg::POSITION_W-1:0];
            end
        end
        if (!res.found)
            res.position = hi[stbs_pkg::POSITION_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        search_result_t head;
        if (!rst_n)
        begin
            entry_count_q = '0;
            signed_keys_q = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no search waiting, position", 0, position);
                else
                begin
                    head = awaited_results.pop_front();
                    if (found !== head.found)
                        report_mismatch("found", head.found, found);
                    if (position !== head.position)
                        report_mismatch("position", head.position, position);
                end
            end
            if (start && !busy)
            begin
                if (op == stbs_pkg::OP_WRITE)
                begin
                    if (32'(entry_index) < TABLE_DEPTH)
                        key_store[entry_index] = entry_value;
                end
                else
                    awaited_results.push_back(predict_search(search_key));
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == stbs_pkg::REG_ENTRY_COUNT)
                    entry_count_q = cfg_data[stbs_pkg::COUNT_W-1:0];
                else if (cfg_index == stbs_pkg::REG_KEY_SIGNED)
                    signed_keys_q = cfg_data[0];
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Fills the table, runs directed searches over empty, full, oversized,
// single-entry, signed and unsorted tables, then random phases that load
// small sorted tables with random register settings and search them, with
// random gaps between items. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 700;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               start       = 1'b0;
    logic [stbs_pkg::OP_W-1:0]          op          = stbs_pkg::OP_WRITE;
    logic [stbs_pkg::ENTRY_INDEX_W-1:0] entry_index = '0;
    logic [stbs_pkg::FIELD_KEY_W-1:0]   entry_value = '0;
    logic [stbs_pkg::FIELD_KEY_W-1:0]   search_key  = '0;
    logic                               cfg_wr_en   = 1'b0;
    logic [stbs_pkg::CFG_INDEX_W-1:0]   cfg_index   = stbs_pkg::REG_ENTRY_COUNT;
    logic [stbs_pkg::CFG_DATA_W-1:0]    cfg_data    = '0;
    logic                               busy;
    logic                               done;
    logic                               found;
    logic [stbs_pkg::POSITION_W-1:0]    position;
    int                                 fail_count;
    int                                 pending;

    logic [stbs_pkg::FIELD_KEY_W-1:0] shadow [TABLE_DEPTH];
    bit                               idling_on = 1'b1;

    always #5 clk = ~clk;

    sorted_table_binary_search DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .done        (done),
        .found       (found),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    stbs_checker #(.TABLE_DEPTH(TABLE_DEPTH)) result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .done        (done),
        .found       (found),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    task automatic send(input logic [stbs_pkg::OP_W-1:0] kind, input int unsigned idx,
                        input logic [stbs_pkg::FIELD_KEY_W-1:0] value,
                        input logic [stbs_pkg::FIELD_KEY_W-1:0] key);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start       <= 1'b0;
            op          <= stbs_pkg::OP_W'($urandom_range(0, 1));
            entry_index <= stbs_pkg::ENTRY_INDEX_W'($urandom);
            entry_value <= $urandom;
            search_key  <= $urandom;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start       <= 1'b1;
        op          <= kind;
        entry_index <= idx[stbs_pkg::ENTRY_INDEX_W-1:0];
        entry_value <= value;
        search_key  <= key;
        if (kind == stbs_pkg::OP_WRITE)
            shadow[idx[stbs_pkg::ENTRY_INDEX_W-1:0]] = value;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [stbs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [stbs_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic logic [stbs_pkg::FIELD_KEY_W-1:0] fill_key(input int unsigned i);
        logic [9:0] hi_bits;
        hi_bits = i[9:0];
        if (i == 0)
            return '0;
        if (i == TABLE_DEPTH - 1)
            return 32'hFFFF_FFFF;
        return {hi_bits, 22'h2A_AAAA};
    endfunction

    function automatic logic [stbs_pkg::FIELD_KEY_W-1:0] pick_key(input int unsigned live);
        int unsigned                      r;
        logic [stbs_pkg::FIELD_KEY_W-1:0] key;
        r   = $urandom_range(0, 9);
        key = $urandom;
        if (live > 0 && r < 5)
            key = shadow[$urandom_range(0, live - 1)];
        else if (live > 0 && r < 7)
            key = shadow[$urandom_range(0, live - 1)] +
                  ($urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF);
        else if (r == 7)
            case ($urandom_range(0, 3))
                0: key = 32'h0000_0000;
                1: key = 32'hFFFF_FFFF;
                2: key = 32'h8000_0000;
                default: key = 32'h7FFF_FFFF;
            endcase
        return key;
    endfunction

    initial
    begin : stimulus
        int unsigned     random_items;
        int unsigned     n;
        int unsigned     count;
        int unsigned     live;
        int unsigned     searches;
        bit              sgn;
        logic [63:0]     level;
        logic [63:0]     step_max;
        logic [31:0]     flip;
        random_items = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: nothing is read, the search misses at zero.
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'hFFFF_FFFF);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send(stbs_pkg::OP_WRITE, i, fill_key(i), $urandom);

        settle();
        write_reg(stbs_pkg::REG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(TABLE_DEPTH));
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0000);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'hFFFF_FFFF);
        send(stbs_pkg::OP_SEARCH, 0, 0, fill_key(511));
        send(stbs_pkg::OP_SEARCH, 0, 0, fill_key(511) + 1);
        send(stbs_pkg::OP_SEARCH, 0, 0, fill_key(TABLE_DEPTH - 2) + 1);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0001);

        // A count above the table depth saturates.
        settle();
        write_reg(stbs_pkg::REG_ENTRY_COUNT, '1);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'hFFFF_FFFF);
        send(stbs_pkg::OP_SEARCH, 0, 0, fill_key(700) - 1);

        settle();
        write_reg(stbs_pkg::REG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(1));
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0000);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0005);

        send(stbs_pkg::OP_WRITE, 0, 32'h8000_0000, 0);
        send(stbs_pkg::OP_WRITE, 1, 32'h8000_0001, 0);
        send(stbs_pkg::OP_WRITE, 2, 32'hC000_0000, 0);
        send(stbs_pkg::OP_WRITE, 3, 32'hFFFF_FFFF, 0);
        send(stbs_pkg::OP_WRITE, 4, 32'h0000_0000, 0);
        send(stbs_pkg::OP_WRITE, 5, 32'h0000_0001, 0);
        send(stbs_pkg::OP_WRITE, 6, 32'h7FFF_FFFE, 0);
        send(stbs_pkg::OP_WRITE, 7, 32'h7FFF_FFFF, 0);
        settle();
        write_reg(stbs_pkg::REG_KEY_SIGNED, stbs_pkg::CFG_DATA_W'(1));
        write_reg(stbs_pkg::REG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(8));
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h8000_0000);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h7FFF_FFFF);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0000);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'hFFFF_FFFE);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h1234_5678);

        // The same table read unsigned is no longer sorted.
        settle();
        write_reg(stbs_pkg::REG_KEY_SIGNED, stbs_pkg::CFG_DATA_W'(0));
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h0000_0000);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h7FFF_FFFF);
        send(stbs_pkg::OP_SEARCH, 0, 0, 32'h8000_0000);

        while (random_items < RANDOM_ITEMS)
        begin
            idling_on = (random_items < RANDOM_ITEMS * 85 / 100) &&
                        ($urandom_range(0, 3) != 0);
            sgn  = $urandom_range(0, 1);
            flip = sgn ? 32'h8000_0000 : 32'h0;
            if ($urandom_range(0, 7) == 0)
                count = $urandom_range(17, 2047);
            else
            begin
                n = $urandom_range(0, 16);
                case ($urandom_range(0, 3))
                    0: level = 64'h0;
                    1: level = 64'hFFFF_FFFF - $urandom_range(0, 64);
                    default: level = {32'h0, $urandom};
                endcase
                step_max = (64'hFFFF_FFFF - level) / (n + 1);
                if ($urandom_range(0, 2) == 0 && step_max > 3)
                    step_max = 3;
                for (int i = 0; i < n; i++)
                begin
                    send(stbs_pkg::OP_WRITE, i, level[31:0] ^ flip, $urandom);
                    level = level + $urandom_range(0, step_max[31:0]);
                end
                random_items += n;
                if (n > 1 && $urandom_range(0, 9) == 0)
                begin
                    send(stbs_pkg::OP_WRITE, $urandom_range(0, n - 1), $urandom, $urandom);
                    random_items++;
                end
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : n;
            end
            settle();
            write_reg(stbs_pkg::REG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(count));
            write_reg(stbs_pkg::REG_KEY_SIGNED,
                      {(stbs_pkg::CFG_DATA_W - 1)'($urandom), sgn});
            live     = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            searches = $urandom_range(3, 12);
            repeat (searches)
            begin
                if (live < TABLE_DEPTH && $urandom_range(0, 11) == 0)
                    send(stbs_pkg::OP_WRITE, $urandom_range(live, TABLE_DEPTH - 1),
                         $urandom, $urandom);
                else
                    send(stbs_pkg::OP_SEARCH, $urandom, $urandom, pick_key(live));
                random_items++;
            end
        end

        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- sorted_table_binary_search.f -----
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/sorted_table_binary_search.sv
dv/stbs_checker.sv
dv/testbench.sv
